// File: rtl/core/rhtd_pkg.sv
// shared types and constants for the run-length half texel decoder
package rhtd_pkg;

    localparam logic [63:0] FNV_BASIS  = 64'hCBF29CE484222325;
    localparam logic [63:0] HASH_PRIME = 64'h00000100000001B3;
    localparam logic [63:0] MAGIC_WORD = 64'h004B50474F463358;
    localparam logic [31:0] PKT_VERSION = 32'd1;
    localparam logic [31:0] HDR_BYTES   = 32'd56;
    localparam logic [5:0]  HDR_LAST    = 6'd55;

    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [3:0] STAT_OK       = 4'd0;
    localparam logic [3:0] STAT_CONFIG   = 4'd1;
    localparam logic [3:0] STAT_MAGIC    = 4'd2;
    localparam logic [3:0] STAT_VERSION  = 4'd3;
    localparam logic [3:0] STAT_META     = 4'd4;
    localparam logic [3:0] STAT_TRUNC    = 4'd5;
    localparam logic [3:0] STAT_RUN      = 4'd6;
    localparam logic [3:0] STAT_HALF     = 4'd7;
    localparam logic [3:0] STAT_TRAILING = 4'd8;
    localparam logic [3:0] STAT_CHECKSUM = 4'd9;

    localparam logic [2:0] REG_PROFILE   = 3'd0;
    localparam logic [2:0] REG_RECIPE    = 3'd1;
    localparam logic [2:0] REG_WIDTH     = 3'd2;
    localparam logic [2:0] REG_HEIGHT    = 3'd3;
    localparam logic [2:0] REG_TEXEL     = 3'd4;
    localparam logic [2:0] REG_DECODED   = 3'd5;
    localparam logic [2:0] REG_CHECKSUM  = 3'd6;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RUNWORD,
        PH_LITERAL,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        S_RUN,
        S_TEST,
        S_MULH,
        S_MULF,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [31:0] profile;
        logic [31:0] recipe;
        logic [31:0] width;
        logic [31:0] height;
        logic [31:0] texel_size;
        logic [31:0] decoded_size;
        logic [63:0] checksum;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] word_index;
        logic [14:0] half_word;
        logic [30:0] zero_words;
        logic [3:0]  status;
        logic        done_res;
    } t_res;

    typedef struct packed {
        logic       take;
        logic       mul_en;
        logic       mul_sel_h;
        logic [1:0] chunk;
        logic       shift_n;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic zero_start;
        logic n_zero;
        logic n_bit0;
        logic n_upper_zero;
        logic pend_eop;
    } t_sts;

endpackage

// File: rtl/core/rle_half_texel_decoder_fnv.sv
// top level of the run-length half texel decoder with fnv-1a 64 check
// Packets arrive one byte per beat on the slave stream, with tlast on the final
// byte. A 56-byte header is checked against the configuration registers, then
// 32-bit run words are decoded: literal runs give one result beat per valid half
// word, zero runs give one beat each, and every packet closes with a status beat
// carrying tlast. A zero run of n words stalls intake while the hash is raised to
// prime^(2n) by square-and-multiply on one 64-bit multiplier that takes the
// second operand 16 bits a cycle: each exponent bit takes a test step and, but
// for the last set bit, a squaring, and a set bit also multiplies the power
// into the hash. Results pass through a four-entry queue, so intake continues
// while the master side stalls until the queue holds three results.
// Configuration is to be written only while no packet is in flight.
module rle_half_texel_decoder_fnv
    import rhtd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pkt_byte
    input  logic        s_tlast,   // end_of_packet
    output logic        m_tvalid,
    input  logic        m_tready,
    // word_index[30:0], half_word[45:31], zero_words[76:46], status[80:77], zero pad
    output logic [87:0] m_tdata,
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,   // done_res
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic push_a, push_b, room, q_valid;
    t_res res_a, res_b, q_res;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers, 8-byte stride
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
            r_cfg.texel_size <= 32'd8;
        end else if (cfg_wr) begin
            case (paddr[5:3])
                REG_PROFILE:  r_cfg.profile      <= pwdata[31:0];
                REG_RECIPE:   r_cfg.recipe       <= pwdata[31:0];
                REG_WIDTH:    r_cfg.width        <= pwdata[31:0];
                REG_HEIGHT:   r_cfg.height       <= pwdata[31:0];
                REG_TEXEL:    r_cfg.texel_size   <= pwdata[31:0];
                REG_DECODED:  r_cfg.decoded_size <= pwdata[31:0];
                REG_CHECKSUM: r_cfg.checksum     <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_PROFILE:  prdata = {32'd0, r_cfg.profile};
            REG_RECIPE:   prdata = {32'd0, r_cfg.recipe};
            REG_WIDTH:    prdata = {32'd0, r_cfg.width};
            REG_HEIGHT:   prdata = {32'd0, r_cfg.height};
            REG_TEXEL:    prdata = {32'd0, r_cfg.texel_size};
            REG_DECODED:  prdata = {32'd0, r_cfg.decoded_size};
            REG_CHECKSUM: prdata = r_cfg.checksum;
            default:      prdata = '0;
        endcase
    end

    // sequencer owns intake and the multiply steps
    rhtd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_room     (room),
        .i_sts      (sts),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    rhtd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (cmd),
        .i_byte   (s_tdata),
        .i_eop    (s_tlast),
        .o_sts    (sts),
        .o_push_a (push_a),
        .o_res_a  (res_a),
        .o_push_b (push_b),
        .o_res_b  (res_b)
    );

    // result queue decouples the master side from intake
    rhtd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_res_a  (res_a),
        .i_push_b (push_b),
        .i_res_b  (res_b),
        .o_room   (room),
        .o_valid  (q_valid),
        .o_res    (q_res),
        .i_pop    (m_tready)
    );

    assign m_tvalid = q_valid;
    assign m_tuser  = q_res.kind;
    assign m_tlast  = q_res.done_res;
    assign m_tdata  = {7'd0, q_res.status, q_res.zero_words, q_res.half_word,
                       q_res.word_index};

    // intake never runs alongside the multiplier or the deferred status
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tready |-> !cmd.mul_en && !cmd.fin)
        else $error("intake open while sequencer busy");

    // the last beat of a packet is always a status beat
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tlast |-> m_tuser == KIND_END)
        else $error("tlast on non-status beat");

    // a deferred status lands in the queue
    a_fin_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin |=> m_tvalid)
        else $error("deferred status lost");

    // a second push always follows a first in the same cycle
    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_b |-> push_a && room)
        else $error("unordered result push");

endmodule

// File: rtl/core/rhtd_outq.sv
// four-entry result queue, up to two pushes and one pop per cycle
module rhtd_outq
    import rhtd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_a,
    input  t_res i_res_a,
    input  logic i_push_b,
    input  t_res i_res_b,
    output logic o_room,
    output logic o_valid,
    output t_res o_res,
    input  logic i_pop
);

    t_res       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] n_wp_b;
    logic [2:0] n_cnt;

    always_comb begin
        n_wp_b = r_wp + 2'd1;
        n_cnt  = r_cnt + {2'b0, i_push_a} + {2'b0, i_push_b} - {2'b0, i_pop && o_valid};
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wp] <= i_res_a;
        end
        if (i_push_b) begin
            r_mem[n_wp_b] <= i_res_b;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + {1'b0, i_push_a} + {1'b0, i_push_b};
            r_rp  <= r_rp + {1'b0, i_pop && o_valid};
            r_cnt <= n_cnt;
        end
    end

    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rp];

endmodule

// File: rtl/core/rhtd_ctrl.sv
// sequencer: byte intake and square-and-multiply steps for zero runs
module rhtd_ctrl
    import rhtd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_room,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_chunk, n_chunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
            r_chunk <= '0;
        end else begin
            r_state <= n_state;
            r_chunk <= n_chunk;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_chunk    = r_chunk;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.chunk = r_chunk;
        case (r_state)
            S_RUN: begin
                o_in_ready = i_room;
                o_cmd.take = i_in_valid && i_room;
                if (o_cmd.take && i_sts.zero_start) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                n_chunk = '0;
                if (i_sts.n_zero) begin
                    n_state = i_sts.pend_eop ? S_FIN : S_RUN;
                end else if (i_sts.n_bit0) begin
                    n_state = S_MULH;
                end else begin
                    n_state = S_MULF;
                end
            end
            S_MULH: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel_h = 1'b1;
                n_chunk = r_chunk + 2'd1;
                if (r_chunk == 2'd3) begin
                    // last set bit: no more squaring needed
                    if (i_sts.n_upper_zero) begin
                        o_cmd.shift_n = 1'b1;
                        n_state = S_TEST;
                    end else begin
                        n_state = S_MULF;
                    end
                end
            end
            S_MULF: begin
                o_cmd.mul_en = 1'b1;
                n_chunk = r_chunk + 2'd1;
                if (r_chunk == 2'd3) begin
                    o_cmd.shift_n = 1'b1;
                    n_state = S_TEST;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_RUN;
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

endmodule

// File: rtl/core/rhtd_dp.sv
// datapath: header check, run decode, fnv hash and power multiplier
module rhtd_dp
    import rhtd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_byte,
    input  logic       i_eop,
    output t_sts       o_sts,
    output logic       o_push_a,
    output t_res       o_res_a,
    output logic       o_push_b,
    output t_res       o_res_b
);

    t_phase      r_phase, n_phase;
    logic [5:0]  r_pos, n_pos;
    logic [63:0] r_fs, n_fs;
    logic [31:0] r_runs, n_runs;
    logic [33:0] r_rlb, n_rlb;
    logic [31:0] r_tp, n_tp;
    logic [7:0]  r_low, n_low;
    logic [63:0] r_hash, n_hash;
    logic [3:0]  r_err, n_err;
    logic        r_pend, n_pend;
    logic [63:0] r_f, n_f;
    logic [33:0] r_n, n_n;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_area;
    logic        r_cfg_ok;

    logic [28:0] total;
    logic        zs;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] t;
        t = h ^ {56'd0, b};
        return (t << 40) + t * 64'd435;
    endfunction

    function automatic t_res end_res(input logic [3:0] st);
        t_res r;
        r = '0;
        r.kind     = KIND_END;
        r.status   = st;
        r.done_res = 1'b1;
        return r;
    endfunction

    function automatic logic [3:0] end_status(
        input t_phase ph, input logic [5:0] pos, input logic [3:0] err,
        input logic [63:0] h, input logic [63:0] cks);
        logic [3:0] st;
        if (ph == PH_HEADER && {26'd0, pos} < HDR_BYTES) begin
            st = STAT_CONFIG;
        end else if (err != STAT_OK) begin
            st = err;
        end else if (ph != PH_DONE) begin
            st = STAT_TRUNC;
        end else if (h != cks) begin
            st = STAT_CHECKSUM;
        end else begin
            st = STAT_OK;
        end
        return st;
    endfunction

    assign total = i_cfg.decoded_size[31:3];

    // config check is registered, sampled at the third header byte
    always_ff @(posedge i_clk) begin
        r_area   <= {32'd0, i_cfg.width} * {32'd0, i_cfg.height};
        r_cfg_ok <= (i_cfg.profile != 32'd0) && (i_cfg.texel_size == 32'd8)
                 && (i_cfg.decoded_size != 32'd0) && (i_cfg.checksum != 64'd0)
                 && (r_area[63:29] == '0) && ({r_area[28:0], 3'b000} == i_cfg.decoded_size);
    end

    always_comb begin
        logic [63:0] fs_in;
        logic [31:0] v;
        logic [31:0] word;
        logic [30:0] count;
        logic [31:0] room;
        logic [2:0]  in_texel;
        logic [15:0] w;
        logic        fin_run;
        logic [63:0] part;
        logic [63:0] sum;
        logic [63:0] opa;
        t_res        dec;
        logic        dec_v;

        n_phase = r_phase; n_pos = r_pos; n_fs = r_fs; n_runs = r_runs;
        n_rlb = r_rlb; n_tp = r_tp; n_low = r_low; n_hash = r_hash;
        n_err = r_err; n_pend = r_pend; n_f = r_f; n_n = r_n; n_acc = r_acc;
        o_push_a = 1'b0; o_push_b = 1'b0; o_res_a = '0; o_res_b = '0;
        zs = 1'b0; dec = '0; dec_v = 1'b0; fin_run = 1'b0;
        fs_in = {i_byte, r_fs[63:8]};
        v = fs_in[63:32];
        word = fs_in[63:32];
        count = word[30:0];
        room = ({3'd0, total} >= r_tp) ? ({3'd0, total} - r_tp) : 32'd0;
        in_texel = 3'd0 - r_rlb[2:0];
        w = {i_byte, r_low};
        opa = i_cmd.mul_sel_h ? r_hash : r_f;
        part = opa * {48'd0, r_f[{i_cmd.chunk, 4'b0000} +: 16]};
        sum = (i_cmd.chunk == 2'd0 ? 64'd0 : r_acc) + (part << {i_cmd.chunk, 4'b0000});

        if (i_cmd.take) begin
            if (r_phase == PH_HEADER) begin
                if ({26'd0, r_pos} < HDR_BYTES) begin
                    n_pos = r_pos + 6'd1;
                end
                if (r_pos == 6'd2 && r_err == STAT_OK && !r_cfg_ok) begin
                    n_err = STAT_CONFIG;
                end
                if (n_err == STAT_OK && {26'd0, r_pos} < HDR_BYTES) begin
                    n_fs = fs_in;
                    case (r_pos)
                        6'd7:  if (fs_in != MAGIC_WORD) n_err = STAT_MAGIC;
                        6'd11: if (v != PKT_VERSION) n_err = STAT_VERSION;
                        6'd15: if (v != HDR_BYTES) n_err = STAT_META;
                        6'd19: if (v != i_cfg.profile) n_err = STAT_META;
                        6'd23: if (v != i_cfg.recipe) n_err = STAT_META;
                        6'd27: if (v != i_cfg.width) n_err = STAT_META;
                        6'd31: if (v != i_cfg.height) n_err = STAT_META;
                        6'd35: if (v != i_cfg.texel_size) n_err = STAT_META;
                        6'd39: if (v != i_cfg.decoded_size) n_err = STAT_META;
                        6'd43: n_runs = v;
                        6'd51: if (fs_in != i_cfg.checksum) n_err = STAT_META;
                        HDR_LAST: begin
                            if (v != 32'd0) begin
                                n_err = STAT_META;
                            end else if (r_runs == 32'd0 || r_runs > {3'd0, total}) begin
                                n_err = STAT_RUN;
                            end else begin
                                n_phase = PH_RUNWORD;
                                n_pos = '0;
                                n_fs = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end else if (r_err == STAT_OK) begin
                case (r_phase)
                    PH_RUNWORD: begin
                        n_fs = fs_in;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == 6'd3) begin
                            n_pos = '0;
                            n_fs = '0;
                            if (count == 31'd0 || {1'b0, count} > room) begin
                                n_err = STAT_RUN;
                            end else if (word[31]) begin
                                n_rlb = {count, 3'b000};
                                n_phase = PH_LITERAL;
                            end else begin
                                zs = 1'b1;
                                n_n = {count, 3'b000};
                                n_f = HASH_PRIME;
                                dec_v = 1'b1;
                                dec.kind = KIND_ZERO;
                                dec.word_index = {r_tp[28:0], 2'b00};
                                dec.zero_words = {count[28:0], 2'b00};
                                n_tp = r_tp + {1'b0, count};
                                fin_run = 1'b1;
                            end
                        end
                    end
                    PH_LITERAL: begin
                        if (!in_texel[0]) begin
                            n_low = i_byte;
                            n_hash = fnv_step(r_hash, i_byte);
                        end else if (w[15] || w[14:10] == 5'h1F) begin
                            n_err = STAT_HALF;
                        end else begin
                            n_hash = fnv_step(r_hash, i_byte);
                            dec_v = 1'b1;
                            dec.kind = KIND_LIT;
                            dec.word_index = {r_tp[28:0], 2'b00} + {29'd0, in_texel[2:1]};
                            dec.half_word = w[14:0];
                        end
                        if (n_err == STAT_OK) begin
                            n_rlb = r_rlb - 34'd1;
                            if (n_rlb[2:0] == 3'd0) begin
                                n_tp = r_tp + 32'd1;
                            end
                            if (n_rlb == 34'd0) begin
                                fin_run = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_err = STAT_TRAILING;
                    end
                endcase
                if (fin_run) begin
                    if (r_runs != 32'd0) begin
                        n_runs = r_runs - 32'd1;
                    end
                    if (n_runs == 32'd0) begin
                        n_phase = PH_DONE;
                        if (n_tp != {3'd0, total}) begin
                            n_err = STAT_TRUNC;
                        end
                    end else begin
                        n_phase = PH_RUNWORD;
                    end
                end
            end
            o_push_a = dec_v;
            o_res_a  = dec;
            if (i_eop) begin
                if (zs) begin
                    n_pend = 1'b1;
                end else begin
                    if (dec_v) begin
                        o_push_b = 1'b1;
                        o_res_b  = end_res(end_status(n_phase, n_pos, n_err, n_hash,
                                                      i_cfg.checksum));
                    end else begin
                        o_push_a = 1'b1;
                        o_res_a  = end_res(end_status(n_phase, n_pos, n_err, n_hash,
                                                      i_cfg.checksum));
                    end
                end
            end
        end else if (i_cmd.mul_en) begin
            n_acc = sum;
            if (i_cmd.chunk == 2'd3) begin
                if (i_cmd.mul_sel_h) begin
                    n_hash = sum;
                end else begin
                    n_f = sum;
                end
            end
        end else if (i_cmd.fin) begin
            o_push_a = 1'b1;
            o_res_a  = end_res(end_status(r_phase, r_pos, r_err, r_hash, i_cfg.checksum));
        end
        if (i_cmd.shift_n) begin
            n_n = r_n >> 1;
        end
        // end of packet returns the decode state, hash and error to the idle packet state
        if ((i_cmd.take && i_eop && !zs) || i_cmd.fin) begin
            n_phase = PH_HEADER; n_pos = '0; n_fs = '0; n_runs = '0; n_rlb = '0;
            n_tp = '0; n_low = '0; n_hash = FNV_BASIS; n_err = STAT_OK; n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f   <= n_f;
        r_acc <= n_acc;
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_fs    <= '0;
            r_runs  <= '0;
            r_rlb   <= '0;
            r_tp    <= '0;
            r_low   <= '0;
            r_hash  <= FNV_BASIS;
            r_err   <= STAT_OK;
            r_pend  <= 1'b0;
            r_n     <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_fs    <= n_fs;
            r_runs  <= n_runs;
            r_rlb   <= n_rlb;
            r_tp    <= n_tp;
            r_low   <= n_low;
            r_hash  <= n_hash;
            r_err   <= n_err;
            r_pend  <= n_pend;
            r_n     <= n_n;
        end
    end

    always_comb begin
        o_sts.zero_start   = zs;
        o_sts.n_zero       = (r_n == '0);
        o_sts.n_bit0       = r_n[0];
        o_sts.n_upper_zero = (r_n[33:1] == '0);
        o_sts.pend_eop     = r_pend;
    end

endmodule
